@@ sv/tpab_pkg.sv @@
// Shared types and constants for the duration add/subtract unit.
// Used by tpab_combine, tpab_breakdown and time_period_add_sub_breakdown.
`default_nettype none

package tpab_pkg;

   localparam logic ACTION_ADD = 1'b0;
   localparam logic ACTION_SUB = 1'b1;

   localparam logic [20:0] USEC_PER_SEC = 21'd1000000;
   localparam logic [19:0] USEC_MAX     = 20'd999999;
   localparam logic [30:0] SEC_MAX      = 31'h7FFF_FFFF;

   localparam int unsigned SEC_PER_DAY  = 86400;
   localparam int unsigned SEC_PER_HOUR = 3600;
   localparam int unsigned SEC_PER_MIN  = 60;
   localparam int unsigned USEC_PER_MS  = 1000;

   // Reciprocals for exact constant division over the operand ranges used.
   // day:    (sec >> 7)  / 675, 24-bit operand, shift 34
   // hour:   (rem >> 4)  / 225, 13-bit operand, shift 21
   // minute: (rem >> 2)  / 15,  10-bit operand, shift 14
   // milli:  (usec >> 3) / 125, 17-bit operand, shift 24
   localparam int unsigned DAY_RECIP  = 25451659;
   localparam int unsigned HOUR_RECIP = 9321;
   localparam int unsigned MIN_RECIP  = 1093;
   localparam int unsigned MS_RECIP   = 134218;

   typedef struct packed {
      logic        action;
      logic [30:0] a_sec;
      logic [19:0] a_usec;
      logic [30:0] b_sec;
      logic [19:0] b_usec;
   } req_type;

   typedef struct packed {
      logic [30:0] total_sec;
      logic [19:0] total_usec;
      logic [14:0] day_count;
      logic [4:0]  hour_part;
      logic [5:0]  minute_part;
      logic [5:0]  second_part;
      logic [9:0]  milli_part;
      logic [9:0]  micro_part;
      logic        overflow;
   } rsp_type;

   typedef struct packed {
      logic [30:0] sec;
      logic [19:0] usec;
      logic        overflow;
   } sum_type;

endpackage

`default_nettype wire

@@ sv/tpab_combine.sv @@
// Two-stage add / absolute-difference of two second+microsecond durations.
// Depends on tpab_pkg.
`default_nettype none

module tpab_combine (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             advance,
   input  wire logic             in_valid,
   input  wire tpab_pkg::req_type in_data,
   output logic                  out_valid,
   output tpab_pkg::sum_type     out_data
);

   logic        s1_valid_ff;
   logic        s1_sub_ff, s1_sub_in;
   logic [30:0] s1_hs_ff, s1_hs_in;
   logic [30:0] s1_ls_ff, s1_ls_in;
   logic [19:0] s1_hu_ff, s1_hu_in;
   logic [19:0] s1_lu_ff, s1_lu_in;

   logic              s2_valid_ff;
   tpab_pkg::sum_type s2_sum_ff, s2_sum_in;

   logic [19:0] a_usec, b_usec;
   logic        swap;

   logic [20:0] sum_usec;
   logic        carry;
   logic [31:0] sum_sec;
   logic [19:0] add_usec;
   logic        borrow;
   logic [19:0] dif_usec;
   logic [30:0] dif_sec;

   // stage 1: clamp and order so the larger duration comes first
   always_comb begin
      a_usec = (in_data.a_usec > tpab_pkg::USEC_MAX) ? tpab_pkg::USEC_MAX : in_data.a_usec;
      b_usec = (in_data.b_usec > tpab_pkg::USEC_MAX) ? tpab_pkg::USEC_MAX : in_data.b_usec;
      swap   = (in_data.a_sec < in_data.b_sec) ||
               ((in_data.a_sec == in_data.b_sec) && (a_usec < b_usec));
      s1_sub_in = (in_data.action == tpab_pkg::ACTION_SUB);
      s1_hs_in  = swap ? in_data.b_sec : in_data.a_sec;
      s1_ls_in  = swap ? in_data.a_sec : in_data.b_sec;
      s1_hu_in  = swap ? b_usec : a_usec;
      s1_lu_in  = swap ? a_usec : b_usec;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_sub_ff <= s1_sub_in;
         s1_hs_ff  <= s1_hs_in;
         s1_ls_ff  <= s1_ls_in;
         s1_hu_ff  <= s1_hu_in;
         s1_lu_ff  <= s1_lu_in;
      end
   end

   // stage 2: carry or borrow, saturate the sum
   always_comb begin
      sum_usec = {1'b0, s1_hu_ff} + {1'b0, s1_lu_ff};
      carry    = (sum_usec >= tpab_pkg::USEC_PER_SEC);
      sum_sec  = {1'b0, s1_hs_ff} + {1'b0, s1_ls_ff} + {31'd0, carry};
      add_usec = carry ? 20'(sum_usec - tpab_pkg::USEC_PER_SEC) : sum_usec[19:0];
      borrow   = (s1_hu_ff < s1_lu_ff);
      dif_usec = borrow ?
                 20'({1'b0, s1_hu_ff} + tpab_pkg::USEC_PER_SEC - {1'b0, s1_lu_ff}) :
                 (s1_hu_ff - s1_lu_ff);
      dif_sec  = s1_hs_ff - s1_ls_ff - {30'd0, borrow};

      if (s1_sub_ff) begin
         s2_sum_in.sec      = dif_sec;
         s2_sum_in.usec     = dif_usec;
         s2_sum_in.overflow = 1'b0;
      end else if (sum_sec[31]) begin
         s2_sum_in.sec      = tpab_pkg::SEC_MAX;
         s2_sum_in.usec     = tpab_pkg::USEC_MAX;
         s2_sum_in.overflow = 1'b1;
      end else begin
         s2_sum_in.sec      = sum_sec[30:0];
         s2_sum_in.usec     = add_usec;
         s2_sum_in.overflow = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_sum_ff <= s2_sum_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_data  = s2_sum_ff;

endmodule

`default_nettype wire

@@ sv/tpab_breakdown.sv @@
// Six-stage split of a duration into days, hours, minutes, seconds,
// milliseconds and microseconds by reciprocal multiplication. Depends on tpab_pkg.
`default_nettype none

module tpab_breakdown (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire logic              in_valid,
   input  wire tpab_pkg::sum_type in_data,
   output logic                   out_valid,
   output tpab_pkg::rsp_type      out_data
);

   logic [5:0] valid_ff;

   // b1: reciprocal products
   logic              [48:0] b1_pday_ff, b1_pday_in;
   logic              [34:0] b1_pms_ff, b1_pms_in;
   tpab_pkg::sum_type        b1_sum_ff;

   // b2: days, remainder, milli and micro
   tpab_pkg::rsp_type b2_rsp_ff, b2_rsp_in;
   logic [16:0]       b2_remd_ff, b2_remd_in;
   logic [31:0]       day_sec;
   logic [19:0]       ms_usec;

   // b3: hour product
   tpab_pkg::rsp_type b3_rsp_ff;
   logic [16:0]       b3_remd_ff;
   logic [26:0]       b3_phr_ff, b3_phr_in;

   // b4: hours and remainder
   tpab_pkg::rsp_type b4_rsp_ff, b4_rsp_in;
   logic [11:0]       b4_remh_ff, b4_remh_in;
   logic [16:0]       hour_sec;

   // b5: minute product
   tpab_pkg::rsp_type b5_rsp_ff;
   logic [11:0]       b5_remh_ff;
   logic [20:0]       b5_pmin_ff, b5_pmin_in;

   // b6: minutes and seconds
   tpab_pkg::rsp_type b6_rsp_ff, b6_rsp_in;
   logic [11:0]       min_sec;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[4:0], in_valid};
      end
   end

   always_comb begin
      b1_pday_in = 49'(in_data.sec[30:7]) * 49'(tpab_pkg::DAY_RECIP);
      b1_pms_in  = 35'(in_data.usec[19:3]) * 35'(tpab_pkg::MS_RECIP);
   end

   always_comb begin
      b2_rsp_in             = '0;
      b2_rsp_in.total_sec   = b1_sum_ff.sec;
      b2_rsp_in.total_usec  = b1_sum_ff.usec;
      b2_rsp_in.overflow    = b1_sum_ff.overflow;
      b2_rsp_in.day_count   = b1_pday_ff[48:34];
      b2_rsp_in.milli_part  = b1_pms_ff[33:24];
      day_sec               = 32'(b1_pday_ff[48:34]) * 32'(tpab_pkg::SEC_PER_DAY);
      ms_usec               = 20'(b1_pms_ff[33:24]) * 20'(tpab_pkg::USEC_PER_MS);
      b2_remd_in            = 17'({1'b0, b1_sum_ff.sec} - day_sec);
      b2_rsp_in.micro_part  = 10'(b1_sum_ff.usec - ms_usec);
   end

   always_comb begin
      b3_phr_in = 27'(b2_remd_ff[16:4]) * 27'(tpab_pkg::HOUR_RECIP);
   end

   always_comb begin
      b4_rsp_in           = b3_rsp_ff;
      b4_rsp_in.hour_part = b3_phr_ff[25:21];
      hour_sec            = 17'(b3_phr_ff[25:21]) * 17'(tpab_pkg::SEC_PER_HOUR);
      b4_remh_in          = 12'(b3_remd_ff - hour_sec);
   end

   always_comb begin
      b5_pmin_in = 21'(b4_remh_ff[11:2]) * 21'(tpab_pkg::MIN_RECIP);
   end

   always_comb begin
      b6_rsp_in             = b5_rsp_ff;
      b6_rsp_in.minute_part = b5_pmin_ff[19:14];
      min_sec               = 12'(b5_pmin_ff[19:14]) * 12'(tpab_pkg::SEC_PER_MIN);
      b6_rsp_in.second_part = 6'(b5_remh_ff - min_sec);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b1_pday_ff <= b1_pday_in;
         b1_pms_ff  <= b1_pms_in;
         b1_sum_ff  <= in_data;
         b2_rsp_ff  <= b2_rsp_in;
         b2_remd_ff <= b2_remd_in;
         b3_rsp_ff  <= b2_rsp_ff;
         b3_remd_ff <= b2_remd_ff;
         b3_phr_ff  <= b3_phr_in;
         b4_rsp_ff  <= b4_rsp_in;
         b4_remh_ff <= b4_remh_in;
         b5_rsp_ff  <= b4_rsp_ff;
         b5_remh_ff <= b4_remh_ff;
         b5_pmin_ff <= b5_pmin_in;
         b6_rsp_ff  <= b6_rsp_in;
      end
   end

   assign out_valid = valid_ff[5];
   assign out_data  = b6_rsp_ff;

endmodule

`default_nettype wire

@@ sv/time_period_add_sub_breakdown.sv @@
// Top level of the duration add/subtract unit with unit breakdown.
// Depends on tpab_pkg, tpab_combine and tpab_breakdown.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  tpab_pkg::req_type
//   rsp      out        rsp_valid/rsp_stall  tpab_pkg::rsp_type
//
// One transaction per cycle while no stalled result is held; each result
// passes through the eight-register pipeline: two for the add/subtract,
// six for the reciprocal-multiply divisions by 86400, 3600, 60 and 1000.
// Reset clears the stage valid bits only.
// A stalled result freezes every stage and stalls the request side.
`default_nettype none

module time_period_add_sub_breakdown (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire tpab_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output tpab_pkg::rsp_type      rsp_payload
);

   logic              advance;
   logic              sum_valid;
   tpab_pkg::sum_type sum_data;

   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   tpab_combine u_combine (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_data   (req_payload),
      .out_valid (sum_valid),
      .out_data  (sum_data)
   );

   tpab_breakdown u_breakdown (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (sum_valid),
      .in_data   (sum_data),
      .out_valid (rsp_valid),
      .out_data  (rsp_payload)
   );

   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.overflow |->
         (rsp_payload.total_sec == tpab_pkg::SEC_MAX) &&
         (rsp_payload.total_usec == tpab_pkg::USEC_MAX))
      else $error("saturated result does not hold the maximum duration");

   a_sec_split: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (32'(rsp_payload.day_count) * 32'(tpab_pkg::SEC_PER_DAY) +
          32'(rsp_payload.hour_part) * 32'(tpab_pkg::SEC_PER_HOUR) +
          32'(rsp_payload.minute_part) * 32'(tpab_pkg::SEC_PER_MIN) +
          32'(rsp_payload.second_part)) == 32'(rsp_payload.total_sec))
      else $error("day/hour/minute/second split does not sum to total_sec");

   a_usec_split: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (20'(rsp_payload.milli_part) * 20'(tpab_pkg::USEC_PER_MS) +
          20'(rsp_payload.micro_part)) == rsp_payload.total_usec)
      else $error("milli/micro split does not sum to total_usec");

   a_minor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_payload.hour_part < 5'd24) && (rsp_payload.minute_part < 6'd60) &&
         (rsp_payload.second_part < 6'd60) && (rsp_payload.micro_part < 10'd1000))
      else $error("breakdown field out of range");

endmodule

`default_nettype wire
